[rtl/assert_macros.svh]
// Assertion macros used by the RTL of the fraction reduction block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge of clk outside reset.
`define FRA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must never be seen at a rising edge of clk outside reset.
`define FRA_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[rtl/fra_pkg.sv]
// Package with the types shared by the fraction reduction block.
package fra_pkg;

   typedef enum logic [1:0] {
      MODE_ADD = 2'd0,
      MODE_SUB = 2'd1,
      MODE_MUL = 2'd2,
      MODE_DIV = 2'd3
   } fra_mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_SETUP,
      ST_GCD,
      ST_DIVN,
      ST_DIVD,
      ST_FINISH
   } fra_state_type;

endpackage

[rtl/fra_mul.sv]
// Shared signed multiplier with a registered product.
module fra_mul #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              enable,
   input  logic signed [OPERAND_WIDTH-1:0]   op_a,
   input  logic signed [OPERAND_WIDTH-1:0]   op_b,
   output logic signed [2*OPERAND_WIDTH-1:0] product
);

   logic signed [2*OPERAND_WIDTH-1:0] product_ff;
   logic signed [2*OPERAND_WIDTH-1:0] product_in;

   assign product_in = op_a * op_b;

   always_ff @(posedge clock) begin
      if (enable) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

[rtl/fraction_arith_reduce.sv]
// Sequence: cross products on the shared multiplier, binary GCD steps, two restoring
// divisions (numerator, then denominator, both by the GCD) and an output step.
// One item at a time: a new transfer can be taken in the cycle after each result is loaded;
// the binary GCD loop and the restoring divider share one subtractor.
// A zero divisor skips both loops: the sequence goes from setup straight to the output step.
// Reset (synchronous, active high) returns the sequencer to idle and drops rsp_valid.
module fraction_arith_reduce #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_mode,
   input  logic signed [OPERAND_WIDTH-1:0]   req_left_numerator,
   input  logic signed [OPERAND_WIDTH-1:0]   req_left_denominator,
   input  logic signed [OPERAND_WIDTH-1:0]   req_right_numerator,
   input  logic signed [OPERAND_WIDTH-1:0]   req_right_denominator,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [2*OPERAND_WIDTH:0]   rsp_result_numerator,
   output logic signed [2*OPERAND_WIDTH-1:0] rsp_result_denominator,
   output logic                              rsp_zero_divisor
);

`include "assert_macros.svh"

   // Product width, and the magnitude width used by the GCD and divider loops.
   localparam int PW = 2 * OPERAND_WIDTH;
   localparam int MW = 2 * OPERAND_WIDTH + 1;
   localparam int KW = $clog2(MW + 1);
   localparam int CW = $clog2(MW + 1);

   fra_pkg::fra_state_type state_ff, state_in;

   // Captured operands of the current transfer.
   fra_pkg::fra_mode_type            mode_ff, mode_in;
   logic signed [OPERAND_WIDTH-1:0]  ln_ff, ln_in, ld_ff, ld_in;
   logic signed [OPERAND_WIDTH-1:0]  rn_ff, rn_in, rd_ff, rd_in;

   // Raw results of the cross products.
   logic [PW-1:0] t0_ff, t0_in;
   logic [MW-1:0] num_ff, num_in;
   logic [PW-1:0] den_ff, den_in;
   logic          zero_ff, zero_in;

   // Binary GCD state: two magnitudes and the count of shared factors of two.
   logic [MW-1:0] ga_ff, ga_in, gb_ff, gb_in;
   logic [KW-1:0] k_ff, k_in;
   logic [MW-1:0] g_ff, g_in;

   // Restoring divider state.
   logic [MW-1:0] rem_ff, rem_in, dq_ff, dq_in, qn_ff, qn_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   // Output register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic [MW-1:0] out_num_ff, out_num_in;
   logic [PW-1:0] out_den_ff, out_den_in;
   logic          out_zero_ff, out_zero_in;

   // Shared multiplier and shared subtractor.
   logic                            mul_en;
   logic signed [OPERAND_WIDTH-1:0] mul_a, mul_b;
   logic signed [PW-1:0]            product;
   logic [MW:0]                     sub_x, sub_y, sub_diff;
   logic                            sub_ge;

   logic [MW-1:0] mag_n, mag_d, mag_p;
   logic [MW:0]   div_shift;
   logic          div_last, out_free;

   fra_mul #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) u_mul (
      .clock  (clock),
      .enable (mul_en),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .product(product)
   );

   assign sub_diff = sub_x - sub_y;
   assign sub_ge   = ~sub_diff[MW];

   // Magnitudes of the raw numerator, the stored denominator and the fresh product.
   assign mag_n = num_ff[MW-1] ? (~num_ff + MW'(1)) : num_ff;
   assign mag_d = {1'b0, (den_ff[PW-1] ? (~den_ff + PW'(1)) : den_ff)};
   assign mag_p = {1'b0, (product[PW-1] ? (~product + PW'(1)) : product)};

   assign div_shift = {rem_ff, dq_ff[MW-1]};
   assign div_last  = (cnt_ff == CW'(MW - 1));
   assign out_free  = ~rsp_valid_ff | rsp_ready;

   assign req_ready              = (state_ff == fra_pkg::ST_IDLE);
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_result_numerator   = out_num_ff;
   assign rsp_result_denominator = out_den_ff;
   assign rsp_zero_divisor       = out_zero_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fra_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = fra_pkg::ST_MUL0;
            end
         end
         fra_pkg::ST_MUL0:  state_in = fra_pkg::ST_MUL1;
         fra_pkg::ST_MUL1:  state_in = fra_pkg::ST_MUL2;
         fra_pkg::ST_MUL2:  state_in = fra_pkg::ST_SETUP;
         fra_pkg::ST_SETUP: begin
            state_in = (product == '0) ? fra_pkg::ST_FINISH : fra_pkg::ST_GCD;
         end
         fra_pkg::ST_GCD: begin
            if (ga_ff == '0) begin
               state_in = fra_pkg::ST_DIVN;
            end
         end
         fra_pkg::ST_DIVN: begin
            if (div_last) begin
               state_in = fra_pkg::ST_DIVD;
            end
         end
         fra_pkg::ST_DIVD: begin
            if (div_last) begin
               state_in = fra_pkg::ST_FINISH;
            end
         end
         fra_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = fra_pkg::ST_IDLE;
            end
         end
         default: state_in = fra_pkg::ST_IDLE;
      endcase
   end

   // Datapath controls and register next values.
   always_comb begin
      mode_in      = mode_ff;
      ln_in        = ln_ff;
      ld_in        = ld_ff;
      rn_in        = rn_ff;
      rd_in        = rd_ff;
      t0_in        = t0_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      zero_in      = zero_ff;
      ga_in        = ga_ff;
      gb_in        = gb_ff;
      k_in         = k_ff;
      g_in         = g_ff;
      rem_in       = rem_ff;
      dq_in        = dq_ff;
      qn_in        = qn_ff;
      cnt_in       = cnt_ff;
      out_num_in   = out_num_ff;
      out_den_in   = out_den_ff;
      out_zero_in  = out_zero_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      mul_en       = 1'b0;
      mul_a        = ln_ff;
      mul_b        = rd_ff;
      sub_x        = {1'b0, ga_ff};
      sub_y        = {1'b0, gb_ff};

      unique case (state_ff)
         fra_pkg::ST_IDLE: begin
            if (req_valid) begin
               mode_in = fra_pkg::fra_mode_type'(req_mode);
               ln_in   = req_left_numerator;
               ld_in   = req_left_denominator;
               rn_in   = req_right_numerator;
               rd_in   = req_right_denominator;
            end
         end
         fra_pkg::ST_MUL0: begin
            // First product: ln*rn for multiply, ln*rd otherwise.
            mul_en = 1'b1;
            mul_a  = ln_ff;
            mul_b  = (mode_ff == fra_pkg::MODE_MUL) ? rn_ff : rd_ff;
         end
         fra_pkg::ST_MUL1: begin
            mul_en = 1'b1;
            mul_a  = rn_ff;
            mul_b  = ld_ff;
            t0_in  = product;
         end
         fra_pkg::ST_MUL2: begin
            // Last product is the raw denominator; the numerator is formed meanwhile.
            mul_en = 1'b1;
            mul_a  = ld_ff;
            mul_b  = (mode_ff == fra_pkg::MODE_DIV) ? rn_ff : rd_ff;
            case (mode_ff)
               fra_pkg::MODE_ADD: num_in = {t0_ff[PW-1], t0_ff} + {product[PW-1], product};
               fra_pkg::MODE_SUB: num_in = {t0_ff[PW-1], t0_ff} - {product[PW-1], product};
               default:           num_in = {t0_ff[PW-1], t0_ff};
            endcase
         end
         fra_pkg::ST_SETUP: begin
            den_in  = product;
            zero_in = (product == '0);
            ga_in   = mag_n;
            gb_in   = mag_p;
            k_in    = '0;
         end
         fra_pkg::ST_GCD: begin
            if (ga_ff == '0) begin
               g_in   = gb_ff << k_ff;
               rem_in = '0;
               dq_in  = mag_n;
               cnt_in = '0;
            end else if (~ga_ff[0] & ~gb_ff[0]) begin
               ga_in = ga_ff >> 1;
               gb_in = gb_ff >> 1;
               k_in  = k_ff + KW'(1);
            end else if (~ga_ff[0]) begin
               ga_in = ga_ff >> 1;
            end else if (~gb_ff[0]) begin
               gb_in = gb_ff >> 1;
            end else if (sub_ge) begin
               ga_in = sub_diff[MW-1:0];
            end else begin
               // Keep the larger value in ga so the next step can subtract.
               ga_in = gb_ff;
               gb_in = ga_ff;
            end
         end
         fra_pkg::ST_DIVN, fra_pkg::ST_DIVD: begin
            sub_x  = div_shift;
            sub_y  = {1'b0, g_ff};
            rem_in = sub_ge ? sub_diff[MW-1:0] : div_shift[MW-1:0];
            dq_in  = {dq_ff[MW-2:0], sub_ge};
            cnt_in = cnt_ff + CW'(1);
            if (div_last && (state_ff == fra_pkg::ST_DIVN)) begin
               qn_in  = {dq_ff[MW-2:0], sub_ge};
               rem_in = '0;
               dq_in  = mag_d;
               cnt_in = '0;
            end
         end
         fra_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_zero_in  = zero_ff;
               if (zero_ff) begin
                  out_num_in = '0;
                  out_den_in = '0;
               end else begin
                  // Both quotients take the sign of their raw value.
                  out_num_in = num_ff[MW-1] ? (~qn_ff + MW'(1)) : qn_ff;
                  out_den_in = den_ff[PW-1] ? (~dq_ff[PW-1:0] + PW'(1)) : dq_ff[PW-1:0];
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fra_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      ln_ff       <= ln_in;
      ld_ff       <= ld_in;
      rn_ff       <= rn_in;
      rd_ff       <= rd_in;
      t0_ff       <= t0_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      zero_ff     <= zero_in;
      ga_ff       <= ga_in;
      gb_ff       <= gb_in;
      k_ff        <= k_in;
      g_ff        <= g_in;
      rem_ff      <= rem_in;
      dq_ff       <= dq_in;
      qn_ff       <= qn_in;
      cnt_ff      <= cnt_in;
      out_num_ff  <= out_num_in;
      out_den_ff  <= out_den_in;
      out_zero_ff <= out_zero_in;
   end

   // A transfer in starts the sequence, so the block stops taking items at once.
   `FRA_ASSERT(a_busy_after_accept, clock, reset, req_valid && req_ready |=> !req_ready, "ready stayed high after a transfer")
   // A zero divisor result carries zero fields.
   `FRA_ASSERT(a_zero_fields, clock, reset, rsp_valid && rsp_zero_divisor |-> rsp_result_numerator == '0 && rsp_result_denominator == '0, "zero divisor result has nonzero fields")
   // A regular result never has a zero denominator.
   `FRA_ASSERT_NEVER(a_den_nonzero, clock, reset, rsp_valid && !rsp_zero_divisor && rsp_result_denominator == '0, "reduced denominator is zero")
   // The divider remainder stays below the divisor throughout both divisions.
   `FRA_ASSERT(a_rem_below_g, clock, reset, (state_ff == fra_pkg::ST_DIVN || state_ff == fra_pkg::ST_DIVD) |-> rem_ff < g_ff, "divider remainder not below the divisor")

endmodule
